FILE: design/sbfm_pkg.sv
// shared types, codes and constants of the servo bus frame master
// no dependencies
`default_nettype none
package sbfm_pkg;

	localparam int SBFM_QUEUE_DEPTH = 4;

	localparam logic [7:0]  SET_CODE_RESET = 8'd211;
	localparam logic [7:0]  GET_CODE_RESET = 8'd199;
	localparam logic [13:0] LIMIT_RESET    = 14'h3FFF;

	// configuration register indexes
	localparam logic [1:0] CFG_SET_CODE = 2'd0;
	localparam logic [1:0] CFG_GET_CODE = 2'd1;
	localparam logic [1:0] CFG_LIMIT    = 2'd2;

	// input func codes
	localparam logic [2:0] FUNC_SET_HDR = 3'd0;
	localparam logic [2:0] FUNC_SET_VAL = 3'd1;
	localparam logic [2:0] FUNC_GET_REQ = 3'd2;
	localparam logic [2:0] FUNC_RX      = 3'd3;
	localparam logic [2:0] FUNC_TIMEOUT = 3'd4;

	// result kinds
	localparam logic [1:0] KIND_TX   = 2'd0;
	localparam logic [1:0] KIND_VAL  = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;

	// queued operation codes
	localparam logic [2:0] OP_TX3      = 3'd0;
	localparam logic [2:0] OP_TX2      = 3'd1;
	localparam logic [2:0] OP_VAL      = 3'd2;
	localparam logic [2:0] OP_VAL_DONE = 3'd3;
	localparam logic [2:0] OP_DONE     = 3'd4;

	// output tdata bit positions
	localparam int TD_TX_LO    = 0;
	localparam int TD_VALUE_LO = 8;
	localparam int TD_SLOT_LO  = 22;
	localparam int TD_OK       = 29;

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] index_start;
		logic [7:0] item_count;
		logic [15:0] set_value;
		logic [7:0] rx_byte;
	} sbfm_item_t;

	typedef struct packed {
		logic [2:0]  code;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic [13:0] value;
		logic [6:0]  slot;
		logic        ok;
	} sbfm_op_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  tx_byte;
		logic [13:0] value;
		logic [6:0]  slot;
		logic        ok;
		logic        last;
	} sbfm_res_t;

	typedef struct packed {
		logic     valid;
		sbfm_op_t op;
	} sbfm_head_t;

	function automatic logic [1:0] op_last_idx(input logic [2:0] code);
		logic [1:0] r;
		case (code)
			OP_TX3:      r = 2'd2;
			OP_TX2:      r = 2'd1;
			OP_VAL_DONE: r = 2'd1;
			default:     r = 2'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: design/sbfm_front.sv
// front part: configuration registers, item decode, set clamp and reply parser
// depends on sbfm_pkg; feeds operations into sbfm_queue
`default_nettype none
module sbfm_front (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     cfg_we,
	input  wire [1:0]               cfg_index,
	input  wire [13:0]              cfg_data,
	input  wire                     accept,
	input  sbfm_pkg::sbfm_item_t    item,
	output logic                    push,
	output sbfm_pkg::sbfm_op_t      op
);
	import sbfm_pkg::*;

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_HUNT  = 3'd1;
	localparam logic [2:0] PH_START = 3'd2;
	localparam logic [2:0] PH_COUNT = 3'd3;
	localparam logic [2:0] PH_LOW   = 3'd4;
	localparam logic [2:0] PH_HIGH  = 3'd5;

	logic [7:0]  set_code_q, get_code_q;
	logic [13:0] limit_q;
	logic [2:0]  phase_q, phase_n;
	logic [6:0]  want_start_q, want_start_n;
	logic [6:0]  want_count_q, want_count_n;
	logic [6:0]  echo_start_q, echo_start_n;
	logic [6:0]  echo_count_q, echo_count_n;
	logic [6:0]  pair_q, pair_n;
	logic [6:0]  low_q, low_n;

	logic [6:0]  st7, cnt7, b7, pair_inc;
	logic [13:0] clamped;

	assign st7      = item.index_start[6:0];
	assign cnt7     = item.item_count[6:0];
	assign b7       = item.rx_byte[6:0];
	assign pair_inc = pair_q + 7'd1;
	assign clamped  = (item.set_value > {2'b00, limit_q}) ? limit_q : item.set_value[13:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_code_q <= SET_CODE_RESET;
			get_code_q <= GET_CODE_RESET;
			limit_q    <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SET_CODE: set_code_q <= cfg_data[7:0];
				CFG_GET_CODE: get_code_q <= cfg_data[7:0];
				CFG_LIMIT:    limit_q    <= cfg_data;
				default:      ;
			endcase
		end
	end

	always_comb begin
		push         = 1'b0;
		op           = '0;
		phase_n      = phase_q;
		want_start_n = want_start_q;
		want_count_n = want_count_q;
		echo_start_n = echo_start_q;
		echo_count_n = echo_count_q;
		pair_n       = pair_q;
		low_n        = low_q;
		if (accept) begin
			unique case (item.func)
				FUNC_SET_HDR, FUNC_GET_REQ: begin
					push    = 1'b1;
					op.code = OP_TX3;
					op.b0   = (item.func == FUNC_SET_HDR) ? set_code_q : get_code_q;
					op.b1   = {1'b0, st7};
					op.b2   = {1'b0, cnt7};
					if (item.func == FUNC_GET_REQ) begin
						want_start_n = st7;
						want_count_n = cnt7;
						echo_start_n = '0;
						echo_count_n = '0;
						pair_n       = '0;
						low_n        = '0;
						phase_n      = PH_HUNT;
					end
				end
				FUNC_SET_VAL: begin
					push    = 1'b1;
					op.code = OP_TX2;
					op.b0   = {1'b0, clamped[6:0]};
					op.b1   = {1'b0, clamped[13:7]};
				end
				FUNC_RX: begin
					unique case (phase_q)
						PH_HUNT: begin
							if (item.rx_byte == get_code_q) phase_n = PH_START;
						end
						PH_START: begin
							echo_start_n = b7;
							phase_n      = PH_COUNT;
						end
						PH_COUNT: begin
							echo_count_n = b7;
							pair_n       = '0;
							if (want_count_q == 7'd0) begin
								push    = 1'b1;
								op.code = OP_DONE;
								op.ok   = (echo_start_q == want_start_q) && (b7 == want_count_q);
								phase_n = PH_IDLE;
							end else begin
								phase_n = PH_LOW;
							end
						end
						PH_LOW: begin
							low_n   = b7;
							phase_n = PH_HIGH;
						end
						PH_HIGH: begin
							push     = 1'b1;
							op.value = {b7, low_q};
							op.slot  = pair_q;
							pair_n   = pair_inc;
							if (pair_inc == want_count_q) begin
								op.code = OP_VAL_DONE;
								op.ok   = (echo_start_q == want_start_q) &&
									(echo_count_q == want_count_q);
								phase_n = PH_IDLE;
							end else begin
								op.code = OP_VAL;
								phase_n = PH_LOW;
							end
						end
						default: phase_n = PH_IDLE;
					endcase
				end
				FUNC_TIMEOUT: begin
					if (phase_q != PH_IDLE) begin
						push    = 1'b1;
						op.code = OP_DONE;
						op.ok   = 1'b0;
						phase_n = PH_IDLE;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			want_start_q <= '0;
			want_count_q <= '0;
			echo_start_q <= '0;
			echo_count_q <= '0;
			pair_q       <= '0;
			low_q        <= '0;
		end else begin
			phase_q      <= phase_n;
			want_start_q <= want_start_n;
			want_count_q <= want_count_n;
			echo_start_q <= echo_start_n;
			echo_count_q <= echo_count_n;
			pair_q       <= pair_n;
			low_q        <= low_n;
		end
	end

endmodule
`default_nettype wire

FILE: design/sbfm_queue.sv
// short register queue of decoded operations between front and back
// depends on sbfm_pkg
`default_nettype none
module sbfm_queue #(
	parameter int DEPTH = sbfm_pkg::SBFM_QUEUE_DEPTH
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  sbfm_pkg::sbfm_op_t    push_op,
	input  wire                   pop,
	output logic                  full,
	output sbfm_pkg::sbfm_head_t  head
);
	import sbfm_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	sbfm_op_t           mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [CNT_W-1:0]   count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.op    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= ptr_next(wr_q);
			if (pop) rd_q <= ptr_next(rd_q);
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: design/sbfm_back.sv
// back part: expands queued ops to results, one per cycle unless stalled
// depends on sbfm_pkg; drives the output register of the master side
`default_nettype none
module sbfm_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  sbfm_pkg::sbfm_head_t  head,
	output logic                  pop,
	input  wire                   out_ready,
	output logic                  out_valid,
	output sbfm_pkg::sbfm_res_t   out_res
);
	import sbfm_pkg::*;

	logic       valid_q;
	sbfm_res_t  res_q, res;
	logic [1:0] idx_q;
	logic [1:0] last_idx;
	logic       load;

	assign last_idx  = op_last_idx(head.op.code);
	assign load      = !valid_q || out_ready;
	assign pop       = load && head.valid && (idx_q == last_idx);
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_comb begin
		res = '0;
		case (head.op.code)
			OP_TX3, OP_TX2: begin
				res.kind    = KIND_TX;
				res.tx_byte = (idx_q == 2'd0) ? head.op.b0 :
					(idx_q == 2'd1) ? head.op.b1 : head.op.b2;
				res.last    = (idx_q == last_idx);
			end
			OP_VAL: begin
				res.kind  = KIND_VAL;
				res.value = head.op.value;
				res.slot  = head.op.slot;
			end
			OP_VAL_DONE: begin
				if (idx_q == 2'd0) begin
					res.kind  = KIND_VAL;
					res.value = head.op.value;
					res.slot  = head.op.slot;
				end else begin
					res.kind = KIND_DONE;
					res.ok   = head.op.ok;
				end
			end
			default: begin
				res.kind = KIND_DONE;
				res.ok   = head.op.ok;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= head.valid;
			if (head.valid) idx_q <= (idx_q == last_idx) ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && head.valid) res_q <= res;
	end

endmodule
`default_nettype wire

FILE: design/servo_bus_frame_master.sv
// top level of the servo bus frame master: front decode, operation queue, back expansion
// depends on sbfm_pkg, sbfm_front, sbfm_queue, sbfm_back
//
//  channel  | signals                          | moves
//  ---------+----------------------------------+-------------------------------
//  slave    | s_tvalid s_tready s_tdata s_tuser | one command or received byte
//  master   | m_tvalid m_tready m_tdata m_tuser | one result, m_tlast ends a run
//           | m_tlast                          |
//  config   | cfg_we cfg_index cfg_data        | register write, no wait
//
// one request accepted per cycle while the operation queue has room
// results leave at one per cycle unless m_tready stalls them; an item gives 0 to 3 results
// an item's results pass through the operation queue, then the output register
// the operation queue lets the front keep taking requests while m_tready is low,
// until it holds QUEUE_DEPTH operations
// reset clears the parser to idle and loads the register defaults
`default_nettype none
module servo_bus_frame_master #(
	parameter int QUEUE_DEPTH = sbfm_pkg::SBFM_QUEUE_DEPTH
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [39:0] s_tdata,  // index_start, item_count, set_value, rx_byte
	input  wire  [2:0]  s_tuser,  // func
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,  // tx_byte, value, slot, ok, zero fill
	output logic [1:0]  m_tuser,  // kind
	output logic        m_tlast,
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_index,
	input  wire  [13:0] cfg_data
);
	import sbfm_pkg::*;

	sbfm_item_t item;
	sbfm_op_t   op;
	sbfm_head_t head;
	sbfm_res_t  res;
	logic       accept, push, pop, full;

	assign item.func        = s_tuser;
	assign item.index_start = s_tdata[7:0];
	assign item.item_count  = s_tdata[15:8];
	assign item.set_value   = s_tdata[31:16];
	assign item.rx_byte     = s_tdata[39:32];

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	sbfm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.item      (item),
		.push      (push),
		.op        (op)
	);

	sbfm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (op),
		.pop     (pop),
		.full    (full),
		.head    (head)
	);

	sbfm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_res   (res)
	);

	assign m_tdata = {2'b00, res.ok, res.slot, res.value, res.tx_byte};
	assign m_tuser = res.kind;
	assign m_tlast = res.last;

endmodule
`default_nettype wire

FILE: design/sbfm_checker.sv
// port-level checks of the servo bus frame master, bound to the top level
// depends on sbfm_pkg and servo_bus_frame_master
`default_nettype none
module sbfm_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [31:0] m_tdata,
	input wire [1:0]  m_tuser,
	input wire        m_tlast
);
	import sbfm_pkg::*;

	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("result valid during reset");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	a_last_tx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == KIND_TX)
		else $error("last flag on a non-transmit result");

	a_done_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_DONE |-> m_tdata[TD_SLOT_LO+6:TD_TX_LO] == '0)
		else $error("done result carries data");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser == KIND_TX || m_tuser == KIND_VAL || m_tuser == KIND_DONE)
		else $error("unknown result kind");

endmodule

bind servo_bus_frame_master sbfm_checker u_sbfm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire

FILE: verif/servo_bus_frame_master_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of servo_bus_frame_master: feeds commands and bus bytes with random
// gaps and output stalls, predicts transmit bytes, reply values and done items, checks each one
// depends on sbfm_pkg and servo_bus_frame_master
module servo_bus_frame_master_tb;
	import sbfm_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES = 150;
	localparam int PHASE_ITEMS = 26;
	localparam logic [2:0] FUNC_FIRST_UNUSED = 3'd5;
	localparam logic [2:0] FUNC_LAST_UNUSED = 3'd7;

	typedef enum logic [2:0] {
		PARSE_IDLE,
		PARSE_HUNT,
		PARSE_START,
		PARSE_COUNT,
		PARSE_LOW,
		PARSE_HIGH
	} parse_phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [39:0] s_tdata = '0;
	logic [2:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0] m_tuser;
	logic m_tlast;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [13:0] cfg_data = '0;

	// predicted register contents and reply parser
	logic [7:0] set_code_q = SET_CODE_RESET;
	logic [7:0] get_code_q = GET_CODE_RESET;
	logic [13:0] limit_q = LIMIT_RESET;
	parse_phase_t parse_phase = PARSE_IDLE;
	logic [6:0] want_start = '0;
	logic [6:0] want_count = '0;
	logic [6:0] echo_start = '0;
	logic [6:0] echo_count = '0;
	logic [6:0] pair_cnt = '0;
	logic [6:0] low_bits = '0;

	sbfm_item_t pending_items[$];
	sbfm_res_t expected_bus_results[$];
	sbfm_item_t offered_item;

	bit idle_on = 1'b1;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	int stim_count = 0;
	int requests_sent = 0;
	int results_checked = 0;
	int mismatches = 0;
	int reg_writes = 0;
	int cycle_count = 0;

	servo_bus_frame_master i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		if (!idle_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic sbfm_res_t bus_result(logic [1:0] kind, logic [7:0] tx, logic [13:0] val,
			logic [6:0] slot, logic ok, logic last);
		sbfm_res_t r;
		r.kind = kind;
		r.tx_byte = tx;
		r.value = val;
		r.slot = slot;
		r.ok = ok;
		r.last = last;
		return r;
	endfunction

	function automatic void expect_result(sbfm_res_t r);
		expected_bus_results.insert(expected_bus_results.size(), r);
	endfunction

	function automatic void finish_reply();
		expect_result(bus_result(KIND_DONE, 8'd0, 14'd0, 7'd0,
			echo_start == want_start && echo_count == want_count, 1'b0));
		parse_phase = PARSE_IDLE;
	endfunction

	function automatic void predict_frame_results(sbfm_item_t it);
		logic [15:0] clamped;
		logic [6:0] b7;
		clamped = (it.set_value > {2'b00, limit_q}) ? {2'b00, limit_q} : it.set_value;
		b7 = it.rx_byte[6:0];
		case (it.func)
			FUNC_SET_HDR, FUNC_GET_REQ: begin
				expect_result(bus_result(KIND_TX,
					it.func == FUNC_SET_HDR ? set_code_q : get_code_q, 14'd0, 7'd0, 1'b0, 1'b0));
				expect_result(bus_result(KIND_TX, {1'b0, it.index_start[6:0]},
					14'd0, 7'd0, 1'b0, 1'b0));
				expect_result(bus_result(KIND_TX, {1'b0, it.item_count[6:0]},
					14'd0, 7'd0, 1'b0, 1'b1));
				if (it.func == FUNC_GET_REQ) begin
					want_start = it.index_start[6:0];
					want_count = it.item_count[6:0];
					echo_start = '0;
					echo_count = '0;
					pair_cnt = '0;
					low_bits = '0;
					parse_phase = PARSE_HUNT;
				end
			end
			FUNC_SET_VAL: begin
				expect_result(bus_result(KIND_TX, {1'b0, clamped[6:0]},
					14'd0, 7'd0, 1'b0, 1'b0));
				expect_result(bus_result(KIND_TX, {1'b0, clamped[13:7]},
					14'd0, 7'd0, 1'b0, 1'b1));
			end
			FUNC_RX: begin
				case (parse_phase)
					PARSE_HUNT: begin
						if (it.rx_byte == get_code_q) parse_phase = PARSE_START;
					end
					PARSE_START: begin
						echo_start = b7;
						parse_phase = PARSE_COUNT;
					end
					PARSE_COUNT: begin
						echo_count = b7;
						pair_cnt = '0;
						if (want_count == 7'd0) finish_reply();
						else parse_phase = PARSE_LOW;
					end
					PARSE_LOW: begin
						low_bits = b7;
						parse_phase = PARSE_HIGH;
					end
					PARSE_HIGH: begin
						expect_result(bus_result(KIND_VAL, 8'd0, {b7, low_bits},
							pair_cnt, 1'b0, 1'b0));
						pair_cnt = pair_cnt + 7'd1;
						if (pair_cnt == want_count) finish_reply();
						else parse_phase = PARSE_LOW;
					end
					default: parse_phase = PARSE_IDLE;
				endcase
			end
			FUNC_TIMEOUT: begin
				if (parse_phase != PARSE_IDLE) begin
					expect_result(bus_result(KIND_DONE, 8'd0, 14'd0, 7'd0,
						1'b0, 1'b0));
					parse_phase = PARSE_IDLE;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predict_frame_results(offered_item);
				requests_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					offered_item = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {offered_item.rx_byte, offered_item.set_value,
						offered_item.item_count, offered_item.index_start};
					s_tuser <= offered_item.func;
					gap_left = pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor and output stalls
	always @(posedge clk) begin : result_monitor
		sbfm_res_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_checked++;
				if (expected_bus_results.size() == 0) begin
					$error("unexpected result: kind %0d, data %h", m_tuser, m_tdata);
					mismatches++;
				end else begin
					want = expected_bus_results.pop_front();
					check_field("kind", 32'(want.kind), 32'(m_tuser));
					check_field("tx_byte", 32'(want.tx_byte), 32'(m_tdata[TD_TX_LO +: 8]));
					check_field("value", 32'(want.value), 32'(m_tdata[TD_VALUE_LO +: 14]));
					check_field("slot", 32'(want.slot), 32'(m_tdata[TD_SLOT_LO +: 7]));
					check_field("ok", 32'(want.ok), 32'(m_tdata[TD_OK]));
					check_field("last", 32'(want.last), 32'(m_tlast));
				end
				// long hold-off so the block fills up and backs up its input
				if (results_checked == 40 || results_checked == 260) hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
				m_tready <= (stall_left == 0);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic push_item(input logic [2:0] func, input logic [7:0] st, input logic [7:0] cnt,
			input logic [15:0] sv, input logic [7:0] b);
		sbfm_item_t it;
		it.func = func;
		it.index_start = st;
		it.item_count = cnt;
		it.set_value = sv;
		it.rx_byte = b;
		pending_items.insert(pending_items.size(), it);
		if (func <= FUNC_TIMEOUT) stim_count++;
	endtask

	task automatic push_rx(input logic [7:0] b);
		push_item(FUNC_RX, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			16'($urandom_range(0, 65535)), b);
	endtask

	// get request followed by a reply, sometimes noisy, mismatched or cut short
	task automatic queue_get_exchange(input logic [6:0] cnt);
		logic [7:0] st_raw;
		logic [7:0] cnt_raw;
		logic [7:0] b;
		int total;
		int cut;
		bit cut_short;
		st_raw = 8'($urandom_range(0, 255));
		cnt_raw = {1'b0, cnt};
		cnt_raw[7] = 1'($urandom_range(0, 1));
		push_item(FUNC_GET_REQ, st_raw, cnt_raw, 16'($urandom_range(0, 65535)),
			8'($urandom_range(0, 255)));
		repeat ($urandom_range(0, 2)) begin
			b = 8'($urandom_range(0, 255));
			if (b == get_code_q) b = b ^ 8'h01;
			push_rx(b);
		end
		if ($urandom_range(0, 4) == 0)
			push_rx(set_code_q == get_code_q ? set_code_q ^ 8'h01 : set_code_q);
		push_rx(get_code_q);
		total = 2 + 2 * cnt;
		cut_short = ($urandom_range(0, 6) == 0);
		cut = cut_short ? $urandom_range(0, total - 1) : total;
		for (int i = 0; i < cut; i++) begin
			b = 8'($urandom_range(0, 255));
			if (i == 0 && $urandom_range(0, 5) != 0) b[6:0] = st_raw[6:0];
			if (i == 1 && $urandom_range(0, 5) != 0) b[6:0] = cnt;
			push_rx(b);
			if ($urandom_range(0, 39) == 0)
				push_item(FUNC_SET_VAL, 8'd0, 8'd0, 16'($urandom_range(0, 65535)), 8'd0);
		end
		if (cut_short && $urandom_range(0, 1) == 1)
			push_item(FUNC_TIMEOUT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
	endtask

	task automatic queue_misc_item();
		int r;
		logic [15:0] v;
		r = $urandom_range(0, 99);
		if (r < 25) begin
			push_item(FUNC_SET_HDR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
		end else if (r < 60) begin
			case ($urandom_range(0, 3))
				0: v = {2'b00, limit_q};
				1: v = {2'b00, limit_q} + 16'd1;
				2: v = (limit_q == 14'd0) ? 16'd0 : {2'b00, limit_q} - 16'd1;
				default: v = 16'($urandom_range(0, 65535));
			endcase
			push_item(FUNC_SET_VAL, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), v,
				8'($urandom_range(0, 255)));
		end else if (r < 80) begin
			push_rx(8'($urandom_range(0, 255)));
		end else if (r < 92) begin
			push_item(FUNC_TIMEOUT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
		end else begin
			push_item(3'($urandom_range(FUNC_FIRST_UNUSED, FUNC_LAST_UNUSED)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic queue_random_phase(input int n);
		int first;
		int c;
		first = stim_count;
		while (stim_count - first < n) begin
			if ($urandom_range(0, 99) < 60) begin
				c = $urandom_range(0, 99);
				queue_get_exchange(7'(c < 70 ? $urandom_range(0, 3) :
					c < 97 ? $urandom_range(4, 12) : $urandom_range(13, 40)));
			end else begin
				queue_misc_item();
			end
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [13:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_SET_CODE: set_code_q = data[7:0];
			CFG_GET_CODE: get_code_q = data[7:0];
			CFG_LIMIT: limit_q = data;
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_items.size() != 0 || s_tvalid || expected_bus_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part at register defaults
		push_item(FUNC_SET_HDR, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
		push_item(FUNC_SET_HDR, 8'h00, 8'h00, 16'h0000, 8'h00);
		push_item(FUNC_SET_VAL, 8'h00, 8'h00, 16'hFFFF, 8'h00);
		push_item(FUNC_SET_VAL, 8'h00, 8'h00, 16'h3FFF, 8'h00);
		push_rx(GET_CODE_RESET);
		push_item(FUNC_TIMEOUT, 8'h00, 8'h00, 16'h0000, 8'h00);
		push_item(FUNC_FIRST_UNUSED, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
		push_item(FUNC_LAST_UNUSED, 8'h00, 8'h00, 16'h0000, 8'h00);
		// zero count reply with noise and a foreign command byte while hunting
		push_item(FUNC_GET_REQ, 8'h85, 8'h80, 16'h0000, 8'h00);
		push_rx(8'h00);
		push_rx(SET_CODE_RESET);
		push_rx(GET_CODE_RESET);
		push_rx(8'h85);
		push_rx(8'h00);
		// one value, payload top bits set
		push_item(FUNC_GET_REQ, 8'h03, 8'h01, 16'h0000, 8'h00);
		push_rx(GET_CODE_RESET);
		push_rx(8'h03);
		push_rx(8'h81);
		push_rx(8'hFF);
		push_rx(8'hFF);
		// restart while armed, then timeout mid reply
		push_item(FUNC_GET_REQ, 8'h01, 8'h02, 16'h0000, 8'h00);
		push_rx(GET_CODE_RESET);
		push_item(FUNC_GET_REQ, 8'h02, 8'h01, 16'h0000, 8'h00);
		push_rx(GET_CODE_RESET);
		push_rx(8'h07);
		push_item(FUNC_TIMEOUT, 8'h00, 8'h00, 16'h0000, 8'h00);
		wait_idle();

		write_reg(CFG_SET_CODE, 14'd128);
		write_reg(CFG_GET_CODE, 14'd255);
		write_reg(CFG_LIMIT, 14'd0);
		@(negedge clk);
		queue_random_phase(PHASE_ITEMS);
		wait_idle();

		write_reg(CFG_SET_CODE, 14'd255);
		write_reg(CFG_GET_CODE, 14'd128);
		write_reg(CFG_LIMIT, 14'h3FFF);
		@(negedge clk);
		idle_on = 1'b0;
		queue_random_phase(PHASE_ITEMS);
		wait_idle();

		write_reg(CFG_SET_CODE, 14'($urandom_range(128, 255)));
		write_reg(CFG_GET_CODE, 14'($urandom_range(128, 255)));
		write_reg(CFG_LIMIT, 14'($urandom_range(0, 16383)));
		@(negedge clk);
		idle_on = 1'b1;
		queue_get_exchange(7'd63);
		queue_random_phase(PHASE_ITEMS);
		wait_idle();

		// same code for set and get, upper write data bits ignored
		write_reg(CFG_SET_CODE, {6'($urandom_range(0, 63)), 8'd200});
		write_reg(CFG_GET_CODE, 14'd200);
		write_reg(CFG_LIMIT, 14'd1);
		@(negedge clk);
		queue_random_phase(PHASE_ITEMS);
		wait_idle();

		write_reg(CFG_SET_CODE, {6'd0, SET_CODE_RESET});
		write_reg(CFG_GET_CODE, {6'd0, GET_CODE_RESET});
		write_reg(CFG_LIMIT, LIMIT_RESET);
		@(negedge clk);
		queue_random_phase(PHASE_ITEMS);
		wait_idle();

		$display("sent %0d requests, checked %0d results, %0d register writes over 6 settings",
			requests_sent, results_checked, reg_writes);
		$display("covered headers, clamped values, hunting, echo mismatch, restarts and timeouts");
		if (mismatches == 0 && expected_bus_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
